FILE: hdl/full_layer_neighbor_gen_top_macros.svh
// Assertion macros for the full-layer neighbour generator.
// Used by full_layer_neighbor_gen_top; expects clk and rst in scope.
`ifndef FULL_LAYER_NEIGHBOR_GEN_TOP_MACROS_SVH
`define FULL_LAYER_NEIGHBOR_GEN_TOP_MACROS_SVH

// same-cycle implication
`define FNG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/fng_pkg.sv
// Shared types, constants and functions of the full-layer neighbour generator.
// No dependencies.
`default_nettype none

package fng_pkg;

  localparam int MAX_DEPTH = 9;
  localparam int DEPTH_W   = 4;
  localparam int BATCH_W   = 6;
  localparam int GROUP_W   = 24;
  localparam int COORD_W   = MAX_DEPTH;
  localparam int KEY_W     = 3 * MAX_DEPTH;
  localparam int IDX_W     = 33;
  localparam int SLOT_W    = 6;
  localparam int SHIFT_W   = 5;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(1);
  localparam logic [SLOT_W-1:0]  SLOT_LAST   = '1;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] z0;
    logic [IDX_W-1:0]   base;
  } item_t;

  function automatic logic [DEPTH_W-1:0] clamp_depth(input logic [DEPTH_W-1:0] d);
    logic [DEPTH_W-1:0] r;
    r = d;
    if (d == '0) r = DEPTH_W'(1);
    if (d > DEPTH_W'(MAX_DEPTH)) r = DEPTH_W'(MAX_DEPTH);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] morton3(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y,
                                               input logic [COORD_W-1:0] z);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int k = 0; k < COORD_W; k++) begin
      key[3*k+2] = x[k];
      key[3*k+1] = y[k];
      key[3*k]   = z[k];
    end
    return key;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/fng_front.sv
// Front end: accepts groups, decodes the Morton corner and batch base.
// Depends on fng_pkg.
`default_nettype none

module fng_front (
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [fng_pkg::BATCH_W-1:0]  batch_index,
  input  wire logic [fng_pkg::GROUP_W-1:0]  group_index,
  input  wire logic [fng_pkg::DEPTH_W-1:0]  tree_depth,
  input  wire logic                         q_full,
  output logic                              push,
  output fng_pkg::item_t                    push_item
);

  logic [fng_pkg::DEPTH_W-1:0] depth;
  logic [fng_pkg::SHIFT_W-1:0] shift;

  always_comb begin
    depth = fng_pkg::clamp_depth(tree_depth);
    shift = fng_pkg::SHIFT_W'(depth) * fng_pkg::SHIFT_W'(3);
    push_item.depth = depth;
    push_item.x0 = '0;
    push_item.y0 = '0;
    push_item.z0 = '0;
    for (int k = 0; k < fng_pkg::MAX_DEPTH - 1; k++) begin
      if (fng_pkg::DEPTH_W'(k + 1) < depth) begin
        push_item.x0[k+1] = group_index[3*k+2];
        push_item.y0[k+1] = group_index[3*k+1];
        push_item.z0[k+1] = group_index[3*k];
      end
    end
    push_item.base = fng_pkg::IDX_W'(batch_index) << shift;
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

FILE: hdl/fng_queue.sv
// Two-entry queue of decoded groups between front and back end.
// Depends on fng_pkg.
`default_nettype none

module fng_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire fng_pkg::item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output fng_pkg::item_t pop_item,
  output logic [1:0]     count
);

  fng_pkg::item_t mem [2];
  logic wr_ptr;
  logic rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) mem[wr_ptr] <= push_item;
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item  = mem[rd_ptr];

endmodule

`default_nettype wire

FILE: hdl/fng_back.sv
// Back end: walks the 64 neighbour slots of a group into the output register.
// Depends on fng_pkg.
`default_nettype none

module fng_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_not_empty,
  input  wire fng_pkg::item_t              q_item,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fng_pkg::SLOT_W-1:0]       slot,
  output logic                             present,
  output logic [fng_pkg::IDX_W-1:0]        neighbor_index,
  output logic                             last
);

  localparam int SW = fng_pkg::COORD_W + 2;

  fng_pkg::item_t               cur;
  logic                         cur_valid;
  logic [fng_pkg::SLOT_W-1:0]   cnt;
  logic                         advance;
  logic                         emit;
  logic                         done;
  logic signed [SW-1:0]         xi;
  logic signed [SW-1:0]         yi;
  logic signed [SW-1:0]         zi;
  logic [SW-2:0]                side;
  logic                         in_grid;
  logic [fng_pkg::IDX_W-1:0]    key_next;

  always_comb begin
    advance = !out_valid || out_ready;
    emit    = advance && cur_valid;
    done    = emit && (cnt == fng_pkg::SLOT_LAST);
    pop     = q_not_empty && (!cur_valid || done);
    side    = (SW-1)'(1) << cur.depth;
    xi = $signed({2'b00, cur.x0}) + $signed(SW'(cnt[5:4])) - SW'(1);
    yi = $signed({2'b00, cur.y0}) + $signed(SW'(cnt[3:2])) - SW'(1);
    zi = $signed({2'b00, cur.z0}) + $signed(SW'(cnt[1:0])) - SW'(1);
    in_grid = !xi[SW-1] && !yi[SW-1] && !zi[SW-1] &&
              (xi[SW-2:0] < side) && (yi[SW-2:0] < side) && (zi[SW-2:0] < side);
    key_next = fng_pkg::IDX_W'(fng_pkg::morton3(xi[fng_pkg::COORD_W-1:0],
                                                yi[fng_pkg::COORD_W-1:0],
                                                zi[fng_pkg::COORD_W-1:0])) + cur.base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
        cnt       <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        cnt <= cnt + fng_pkg::SLOT_W'(1);
      end
      if (advance) out_valid <= cur_valid;
    end
    if (pop) cur <= q_item;
    if (emit) begin
      slot           <= cnt;
      present        <= in_grid;
      neighbor_index <= in_grid ? key_next : '0;
      last           <= (cnt == fng_pkg::SLOT_LAST);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/full_layer_neighbor_gen_top.sv
// Usage of full_layer_neighbor_gen_top
// Input channel (in_valid/in_ready, batch_index, group_index) takes one
// sibling group of a full octree layer per transfer. Each group yields 64
// result transfers on the output channel (out_valid/out_ready, slot,
// present, neighbor_index, last), slots 0..63 in order, last on slot 63.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the layer
// depth; cfg_ready is always high. Write it only while the block is idle.
// The first result of a group passes the queue, the back end's group
// register and the output register. Throughput: one result per cycle
// while out_ready does not stall the output, set by the slot counter of
// the back end; groups follow each other with no gap. A two-entry queue
// holds decoded groups, so input keeps being taken while results are
// stalled until it fills. With out_valid high and out_ready low, the
// output register holds and the slot walk halts. Synchronous reset
// empties the queue, drops any group in progress and sets depth to one.
// Depends on fng_pkg, fng_front, fng_queue, fng_back and the macro header.
`default_nettype none
`include "full_layer_neighbor_gen_top_macros.svh"

module full_layer_neighbor_gen_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [fng_pkg::DEPTH_W-1:0] cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [fng_pkg::BATCH_W-1:0] batch_index,
  input  wire logic [fng_pkg::GROUP_W-1:0] group_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [fng_pkg::SLOT_W-1:0]       slot,
  output logic                             present,
  output logic [fng_pkg::IDX_W-1:0]        neighbor_index,
  output logic                             last
);

  logic [fng_pkg::DEPTH_W-1:0] tree_depth;
  logic                        q_full;
  logic                        q_not_empty;
  logic                        push;
  logic                        pop;
  logic [1:0]                  q_count;
  fng_pkg::item_t              push_item;
  fng_pkg::item_t              pop_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tree_depth <= fng_pkg::DEPTH_RESET;
    end else if (cfg_valid) begin
      tree_depth <= cfg_data;
    end
  end

  fng_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .batch_index (batch_index),
    .group_index (group_index),
    .tree_depth  (tree_depth),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  fng_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item),
    .count     (q_count)
  );

  fng_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_not_empty    (q_not_empty),
    .q_item         (pop_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .slot           (slot),
    .present        (present),
    .neighbor_index (neighbor_index),
    .last           (last)
  );

  `FNG_ASSERT_NOW(a_absent_zero, out_valid && !present, neighbor_index == '0, "absent slot with nonzero index")
  `FNG_ASSERT_NOW(a_last_slot, out_valid, last == (slot == fng_pkg::SLOT_LAST), "last flag off slot 63")
  `FNG_ASSERT_NEXT(a_slot_walk, out_valid && out_ready && !last, out_valid && (slot == $past(slot) + 6'd1), "slot walk broken")
  `FNG_ASSERT_NOW(a_queue_bound, 1'b1, q_count != 2'd3 && !(push && q_full), "queue overflow")

endmodule

`default_nettype wire
